@@ rtl/core/sf_pkg.sv @@
// Shared constants, register codes and types for the signal framer.
`timescale 1ns / 1ps
package sf_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned MAX_LEN    = 64;
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_AW    = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned STEP_W     = 12;
  localparam int unsigned OFS_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_LEN  = 2'd0,
    CFG_HOP      = 2'd1,
    CFG_PAD_END  = 2'd2,
    CFG_PAD_WORD = 2'd3
  } cfg_idx_t;

  // Input commands
  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  // Raw configuration register contents
  typedef struct packed {
    logic [LEN_W-1:0]  win_len;
    logic [STEP_W-1:0] hop;
    logic              pad_end;
    logic [WORD_W-1:0] pad_word;
  } cfg_t;

  // Ring write request from the sequencer
  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [WORD_W-1:0]  data;
  } ring_wr_t;

  // Ring read request from the sequencer
  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
  } ring_rd_t;

endpackage

@@ rtl/core/sf_ring.sv @@
// Sample ring: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module sf_ring (
  input  logic                       clk,
  input  sf_pkg::ring_wr_t           wr,
  input  sf_pkg::ring_rd_t           rd,
  output logic [sf_pkg::WORD_W-1:0]  rd_data
);

  logic [sf_pkg::WORD_W-1:0] mem [sf_pkg::RING_DEPTH];

  // Write the pushed sample
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

@@ rtl/core/sf_ctrl.sv @@
// Framing sequencer: counters, frame detection and per-word readout.
`timescale 1ns / 1ps
module sf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sf_pkg::cfg_t                  cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [sf_pkg::WORD_W-1:0]     in_sample,
  input  logic                          in_last,
  output sf_pkg::ring_wr_t              ring_wr,
  output sf_pkg::ring_rd_t              ring_rd,
  input  logic [sf_pkg::WORD_W-1:0]     ring_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sf_pkg::WORD_W-1:0]     out_value,
  output logic [sf_pkg::CNT_W-1:0]      out_frame_index,
  output logic [sf_pkg::OFS_W-1:0]      out_offset,
  output logic                          out_is_pad,
  output logic                          out_frame_last,
  output logic                          out_signal_done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [sf_pkg::CNT_W-1:0]    seen_r, seen_nxt;
  logic [sf_pkg::CNT_W-1:0]    start_r, start_nxt;
  logic [sf_pkg::CNT_W-1:0]    num_r, num_nxt;
  logic                        ended_r, ended_nxt;
  logic [sf_pkg::CNT_W-1:0]    fr_start_r, fr_start_nxt;
  logic [sf_pkg::CNT_W-1:0]    fr_num_r, fr_num_nxt;
  logic [sf_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [sf_pkg::LEN_W-1:0]    avail_r, avail_nxt;
  logic                        done_r, done_nxt;
  logic [sf_pkg::OFS_W-1:0]    k_r, k_nxt;

  logic [sf_pkg::LEN_W-1:0]    eff_len;
  logic [sf_pkg::STEP_W-1:0]   eff_step;
  logic                        accept;
  logic                        is_push;
  logic [sf_pkg::CNT_W-1:0]    base_seen, base_start, base_num;
  logic [sf_pkg::CNT_W-1:0]    seen_upd;
  logic [sf_pkg::CNT_W-1:0]    span;
  logic [sf_pkg::CNT_W-1:0]    start_adv;
  logic [sf_pkg::CNT_W-1:0]    rest;
  logic [sf_pkg::CNT_W-1:0]    len_ext;
  logic                        fire;
  logic                        pad_left;
  logic                        last_word;

  // Clamp the configured length and step to their legal ranges
  always_comb begin
    if (cfg.win_len == '0) begin
      eff_len = sf_pkg::LEN_W'(1);
    end else if (cfg.win_len > sf_pkg::LEN_W'(sf_pkg::MAX_LEN)) begin
      eff_len = sf_pkg::LEN_W'(sf_pkg::MAX_LEN);
    end else begin
      eff_len = cfg.win_len;
    end
    eff_step = (cfg.hop == '0) ? sf_pkg::STEP_W'(1) : cfg.hop;
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_push  = (in_cmd == sf_pkg::CMD_PUSH);
  assign len_ext  = sf_pkg::CNT_W'(eff_len);

  // Decide whether the accepted item completes or drains a frame
  always_comb begin
    if (is_push && ended_r) begin
      base_seen  = '0;
      base_start = '0;
      base_num   = '0;
    end else begin
      base_seen  = seen_r;
      base_start = start_r;
      base_num   = num_r;
    end
    seen_upd  = is_push ? (base_seen + sf_pkg::CNT_W'(1)) : base_seen;
    span      = seen_upd - base_start;
    start_adv = base_start + sf_pkg::CNT_W'(eff_step);
    rest      = seen_upd - start_adv;
    pad_left  = cfg.pad_end && (rest != '0) && (rest < len_ext);
    if (is_push) begin
      fire = (span == len_ext);
    end else begin
      fire = ended_r && cfg.pad_end && (span != '0) && (span < len_ext);
    end
  end

  // Sequence: accept, then read and present one word per frame position
  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    start_nxt    = start_r;
    num_nxt      = num_r;
    ended_nxt    = ended_r;
    fr_start_nxt = fr_start_r;
    fr_num_nxt   = fr_num_r;
    len_nxt      = len_r;
    avail_nxt    = avail_r;
    done_nxt     = done_r;
    k_nxt        = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_push) begin
            seen_nxt  = seen_upd;
            start_nxt = base_start;
            num_nxt   = base_num;
            ended_nxt = in_last;
          end
          if (fire) begin
            fr_start_nxt = base_start;
            fr_num_nxt   = base_num;
            start_nxt    = start_adv;
            num_nxt      = base_num + sf_pkg::CNT_W'(1);
            len_nxt      = eff_len;
            avail_nxt    = span[sf_pkg::LEN_W-1:0];
            done_nxt     = (!is_push || in_last) && !pad_left;
            k_nxt        = '0;
            state_nxt    = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_word) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + sf_pkg::OFS_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= '0;
      start_r <= '0;
      num_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      start_r <= start_nxt;
      num_r   <= num_nxt;
      ended_r <= ended_nxt;
    end
  end

  // Hold the frame being emitted
  always_ff @(posedge clk) begin
    fr_start_r <= fr_start_nxt;
    fr_num_r   <= fr_num_nxt;
    len_r      <= len_nxt;
    avail_r    <= avail_nxt;
    done_r     <= done_nxt;
    k_r        <= k_nxt;
  end

  // Ring accesses
  assign ring_wr.en   = accept && is_push;
  assign ring_wr.addr = base_seen[sf_pkg::RING_AW-1:0];
  assign ring_wr.data = in_sample;
  assign ring_rd.en   = (state_r == S_READ);
  assign ring_rd.addr = fr_start_r[sf_pkg::RING_AW-1:0] + k_r;

  // Present the current word
  assign last_word       = ((sf_pkg::LEN_W'(k_r) + sf_pkg::LEN_W'(1)) == len_r);
  assign out_valid       = (state_r == S_OUT);
  assign out_is_pad      = (sf_pkg::LEN_W'(k_r) >= avail_r);
  assign out_value       = out_is_pad ? cfg.pad_word : ring_data;
  assign out_frame_index = fr_num_r;
  assign out_offset      = k_r;
  assign out_frame_last  = last_word;
  assign out_signal_done = last_word && done_r;

endmodule

@@ rtl/core/signal_framer.sv @@
// Top level: stream ports, configuration registers, sequencer and ring.
// Flow: a push that completes a frame moves the sequencer from idle to reading;
// each word of the frame is read from the ring (registered), then output.
// Stalls: items with no results leave the input ready; the input is held off
// until the last word of a frame is taken.
// Reset: synchronous active-low rst_n clears counters, state and config registers
// (window length 1, hop 1, pad_end 0, pad_word 0); ring contents stay.
`timescale 1ns / 1ps
module signal_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] sample
  input  logic                            in_tuser,   // [0] cmd
  input  logic                            in_tlast,   // last_sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] value, [55:32] frame_index, [61:56] offset_in_frame, [63:62] zero
  output logic [63:0]                     out_tdata,
  output logic [1:0]                      out_tuser,  // [0] is_pad, [1] signal_done
  output logic                            out_tlast,  // frame_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                     cfg_data
);

  sf_pkg::cfg_t                 cfg_r, cfg_nxt;
  sf_pkg::ring_wr_t             ring_wr;
  sf_pkg::ring_rd_t             ring_rd;
  logic [sf_pkg::WORD_W-1:0]    ring_data;
  logic [sf_pkg::WORD_W-1:0]    o_value;
  logic [sf_pkg::CNT_W-1:0]     o_frame_index;
  logic [sf_pkg::OFS_W-1:0]     o_offset;
  logic                         o_is_pad;
  logic                         o_signal_done;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (sf_pkg::cfg_idx_t'(cfg_index))
        sf_pkg::CFG_WIN_LEN:  cfg_nxt.win_len  = cfg_data[sf_pkg::LEN_W-1:0];
        sf_pkg::CFG_HOP:      cfg_nxt.hop      = cfg_data[sf_pkg::STEP_W-1:0];
        sf_pkg::CFG_PAD_END:  cfg_nxt.pad_end  = cfg_data[0];
        sf_pkg::CFG_PAD_WORD: cfg_nxt.pad_word = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_len  <= sf_pkg::LEN_W'(1);
      cfg_r.hop      <= sf_pkg::STEP_W'(1);
      cfg_r.pad_end  <= 1'b0;
      cfg_r.pad_word <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_cmd          (in_tuser),
    .in_sample       (in_tdata),
    .in_last         (in_tlast),
    .ring_wr         (ring_wr),
    .ring_rd         (ring_rd),
    .ring_data       (ring_data),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_value       (o_value),
    .out_frame_index (o_frame_index),
    .out_offset      (o_offset),
    .out_is_pad      (o_is_pad),
    .out_frame_last  (out_tlast),
    .out_signal_done (o_signal_done)
  );

  sf_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd      (ring_rd),
    .rd_data (ring_data)
  );

  // Pack result fields
  assign out_tdata = {2'b00, o_offset, o_frame_index, o_value};
  assign out_tuser = {o_signal_done, o_is_pad};

endmodule
